[hw/rtl/gsa_pkg.sv]
package gsa_pkg;

  // Field widths of the request and response transactions.
  localparam int REQ_W       = 2;
  localparam int IDX_FIELD_W = 8;
  localparam int GEN_FIELD_W = 16;
  localparam int STATUS_W    = 2;

  typedef logic [REQ_W-1:0]       req_kind_t;
  typedef logic [IDX_FIELD_W-1:0] idx_field_t;
  typedef logic [GEN_FIELD_W-1:0] gen_field_t;
  typedef logic [STATUS_W-1:0]    status_t;

  // Request kinds.
  localparam req_kind_t REQ_CREATE   = 2'd0;
  localparam req_kind_t REQ_DESTROY  = 2'd1;
  localparam req_kind_t REQ_VALIDATE = 2'd2;
  localparam req_kind_t REQ_GET      = 2'd3;

  // Response status codes.
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

endpackage

[hw/rtl/gsa_req_if.sv]
interface gsa_req_if;
  import gsa_pkg::*;

  logic       valid;
  logic       ready;
  req_kind_t  req_type;
  idx_field_t slot_index;
  gen_field_t slot_generation;

  modport source (output valid, output req_type, output slot_index,
                  output slot_generation, input ready);
  modport sink   (input valid, input req_type, input slot_index,
                  input slot_generation, output ready);
endinterface

[hw/rtl/gsa_rsp_if.sv]
interface gsa_rsp_if;
  import gsa_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  logic       handle_valid;
  idx_field_t out_index;
  gen_field_t out_generation;

  modport source (output valid, output status, output handle_valid,
                  output out_index, output out_generation, input ready);
  modport sink   (input valid, input status, input handle_valid,
                  input out_index, input out_generation, output ready);
endinterface

[hw/rtl/generational_slot_allocator_unit.sv]
// Generational slot allocator. Each request transaction (create, destroy,
// validate or get) yields exactly one response transaction, in order. When
// a request is accepted the slot table and the free stack are read from their
// synchronous memories; then, in the execute state, the request is resolved,
// the memories are written back and the response is loaded into the output
// register. Because of the read-modify-write of the slot table, a new request
// is not accepted until the previous one is resolved; a response that is not
// taken holds the block in its execute state until the output register frees
// up. A new request is accepted while the previous response still waits in
// the output register.
// No clearing pass is needed after reset: slots at or above the never-used
// mark are treated as dead, so the block is ready as soon as reset goes low.
// Slot 0 is never handed out, and generations wrap at GEN_BITS bits.
module generational_slot_allocator_unit #(
  parameter int MAX_SLOTS = 256,
  parameter int GEN_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst,
  gsa_req_if.sink   req,
  gsa_rsp_if.source rsp
);
  import gsa_pkg::*;

  localparam int IDX_W = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (GEN_BITS > GEN_FIELD_W) ? GEN_BITS : GEN_FIELD_W;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [GEN_BITS-1:0] gen_t;

  // One slot table entry: liveness and current generation.
  typedef struct packed {
    logic live;
    gen_t gen;
  } tbl_entry_t;

  // A free stack entry carries the slot and the generation it will be
  // reissued with, so a pop needs no second table read.
  typedef struct packed {
    idx_t idx;
    gen_t gen;
  } stk_entry_t;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;

  // Memories.
  tbl_entry_t tbl_mem [MAX_SLOTS];
  stk_entry_t stk_mem [MAX_SLOTS];
  tbl_entry_t tbl_rd;
  stk_entry_t stk_rd;

  // Allocator bookkeeping.
  cnt_t free_count;
  cnt_t free_count_next;
  cnt_t next_unused;
  cnt_t next_unused_next;

  // Request captured at accept.
  req_kind_t  req_kind;
  idx_field_t req_index;
  gen_field_t req_gen;

  // Output register.
  logic       out_valid;
  status_t    out_status;
  logic       out_hvalid;
  idx_field_t out_index;
  gen_field_t out_gen;

  // Resolved response and memory writes for the request in flight.
  status_t    res_status;
  logic       res_hvalid;
  idx_field_t res_index;
  gen_field_t res_gen;
  logic       tbl_we;
  idx_t       tbl_waddr;
  tbl_entry_t tbl_wdata;
  logic       stk_we;
  stk_entry_t stk_wdata;
  logic       handle_ok;
  gen_t       gen_inc;

  logic accept;
  logic finish;

  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  // The request resolves once the output register is free or being emptied.
  assign finish    = (state == S_EXEC) && (!out_valid || rsp.ready);

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.handle_valid   = out_hvalid;
  assign rsp.out_index      = out_index;
  assign rsp.out_generation = out_gen;

  // Slot table: read at the handle's index when a request is accepted.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (accept) begin
      tbl_rd <= tbl_mem[idx_t'(req.slot_index)];
    end
  end

  // Free stack: the top entry is read at accept, a push lands at free_count.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[idx_t'(free_count)] <= stk_wdata;
    end
    if (accept) begin
      stk_rd <= stk_mem[idx_t'(free_count - 1'b1)];
    end
  end

  // A handle is good when its index is in range and not zero, lies below the
  // never-used mark (so its table entry has been written), the slot is live
  // and the generations agree. The never-used mark does not move between the
  // read and this check.
  assign handle_ok = (req_index != '0)
                  && (32'(req_index) < 32'(MAX_SLOTS))
                  && (32'(req_index) < 32'(next_unused))
                  && tbl_rd.live
                  && (CMP_W'(tbl_rd.gen) == CMP_W'(req_gen));

  assign gen_inc = tbl_rd.gen + 1'b1;

  always_comb begin
    res_status       = ST_OK;
    res_hvalid       = 1'b0;
    res_index        = '0;
    res_gen          = '0;
    tbl_we           = 1'b0;
    tbl_waddr        = idx_t'(req_index);
    tbl_wdata        = '{live: 1'b0, gen: gen_inc};
    stk_we           = 1'b0;
    stk_wdata        = '{idx: idx_t'(req_index), gen: gen_inc};
    free_count_next  = free_count;
    next_unused_next = next_unused;

    if (req_kind == REQ_CREATE) begin
      if (free_count != '0) begin
        // Reuse the most recently freed slot.
        tbl_we          = 1'b1;
        tbl_waddr       = stk_rd.idx;
        tbl_wdata       = '{live: 1'b1, gen: stk_rd.gen};
        free_count_next = free_count - 1'b1;
        res_hvalid      = 1'b1;
        res_index       = IDX_FIELD_W'(stk_rd.idx);
        res_gen         = GEN_FIELD_W'(stk_rd.gen);
      end else if (next_unused < cnt_t'(MAX_SLOTS)) begin
        // Take a fresh slot, starting at generation one.
        tbl_we           = 1'b1;
        tbl_waddr        = idx_t'(next_unused);
        tbl_wdata        = '{live: 1'b1, gen: gen_t'(1)};
        next_unused_next = next_unused + 1'b1;
        res_hvalid       = 1'b1;
        res_index        = IDX_FIELD_W'(next_unused);
        res_gen          = GEN_FIELD_W'(gen_t'(1));
      end else begin
        res_status = ST_FULL;
      end
    end else if (handle_ok) begin
      res_hvalid = 1'b1;
      if (req_kind == REQ_DESTROY) begin
        // Retire the slot, bump its generation and push it for reuse.
        tbl_we = 1'b1;
        if (free_count < cnt_t'(MAX_SLOTS)) begin
          stk_we          = 1'b1;
          free_count_next = free_count + 1'b1;
        end
      end else if (req_kind == REQ_GET) begin
        res_index = req_index;
        res_gen   = GEN_FIELD_W'(tbl_rd.gen);
      end
    end else begin
      res_status = ST_INVALID;
    end

    tbl_we = tbl_we && finish;
    stk_we = stk_we && finish;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      free_count  <= '0;
      next_unused <= cnt_t'(1);
    end else begin
      // A new response replaces the one being taken in the same cycle.
      if (finish) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_kind  <= req.req_type;
            req_index <= req.slot_index;
            req_gen   <= req.slot_generation;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (finish) begin
            out_status  <= res_status;
            out_hvalid  <= res_hvalid;
            out_index   <= res_index;
            out_gen     <= res_gen;
            free_count  <= free_count_next;
            next_unused <= next_unused_next;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Every freed slot was once handed out, so the stack never holds more
  // entries than slots taken from the never-used range.
  a_free_below_mark: assert property (@(posedge clk) disable iff (rst)
    free_count < next_unused)
    else $error("free stack holds more slots than were ever issued");

  // The read and the write-back of one request never overlap the next read.
  a_interlock: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while the previous one is unresolved");

  // A response reports a good handle exactly when its status is OK.
  a_status_agrees: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_status == ST_OK) == out_hvalid))
    else $error("response status and handle_valid disagree");

  // A handle issued by a create never names the reserved slot.
  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (finish && res_hvalid && (req_kind == REQ_CREATE)) |-> (res_index != '0 ||
      32'(MAX_SLOTS) > 32'(1 << IDX_FIELD_W)))
    else $error("create issued the reserved slot");

endmodule

[tb/gsa_alloc_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the slot allocator, keeps its own copy of the slot
// tables and the free stack, and compares every response transaction with
// the response it predicts for the oldest request not yet answered.
module gsa_alloc_checker #(
  parameter int MAX_SLOTS = 256,
  parameter int GEN_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  gsa_req_if   req,
  gsa_rsp_if   rsp,
  output int   fail_count,
  output int   outstanding
);
  import gsa_pkg::*;

  typedef struct packed {
    status_t    status;
    logic       handle_valid;
    idx_field_t index;
    gen_field_t generation;
  } alloc_rsp_t;

  bit                  slot_alive [MAX_SLOTS];
  logic [GEN_BITS-1:0] slot_gens  [MAX_SLOTS];
  int                  free_slots [MAX_SLOTS];
  int                  free_depth;
  int                  next_fresh;

  alloc_rsp_t expected_rsps[$];
  alloc_rsp_t exp_rsp;
  int         errors = 0;

  assign fail_count = errors;

  // A handle names a live slot only with the right index and generation.
  function automatic bit handle_names_live(idx_field_t idx, gen_field_t gen);
    logic [63:0] stored;
    logic [63:0] given;
    if (idx == 0 || int'(idx) >= MAX_SLOTS) return 1'b0;
    if (!slot_alive[idx]) return 1'b0;
    stored = 64'(slot_gens[idx]);
    given  = 64'(gen);
    return stored == given;
  endfunction

  // Applies one request to the shadow tables and returns its response.
  function automatic alloc_rsp_t resolve_request(req_kind_t kind, idx_field_t idx,
                                                 gen_field_t gen);
    alloc_rsp_t r;
    int         s;
    bit         got;
    r   = '0;
    s   = 0;
    got = 1'b0;
    if (kind == REQ_CREATE) begin
      if (free_depth > 0) begin
        free_depth--;
        s   = free_slots[free_depth];
        got = s < MAX_SLOTS;
      end else if (next_fresh < MAX_SLOTS) begin
        s = next_fresh;
        next_fresh++;
        slot_gens[s] = GEN_BITS'(1);
        got = 1'b1;
      end
      if (got) begin
        slot_alive[s]  = 1'b1;
        r.status       = ST_OK;
        r.handle_valid = 1'b1;
        r.index        = idx_field_t'(s);
        r.generation   = gen_field_t'(slot_gens[s]);
      end else begin
        r.status = ST_FULL;
      end
    end else if (handle_names_live(idx, gen)) begin
      r.status       = ST_OK;
      r.handle_valid = 1'b1;
      if (kind == REQ_DESTROY) begin
        slot_alive[idx] = 1'b0;
        slot_gens[idx]  = slot_gens[idx] + 1'b1;
        if (free_depth < MAX_SLOTS) begin
          free_slots[free_depth] = int'(idx);
          free_depth++;
        end
      end else if (kind == REQ_GET) begin
        r.index      = idx;
        r.generation = gen_field_t'(slot_gens[idx]);
      end
    end else begin
      r.status = ST_INVALID;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot_alive[i] = 1'b0;
        slot_gens[i]  = '0;
        free_slots[i] = 0;
      end
      free_depth = 0;
      next_fresh = 1;
      expected_rsps.delete();
    end else begin
      // Responses are checked before this edge's request is predicted, since a
      // request can never be answered at the edge that accepts it.
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response transaction with no request outstanding");
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
            errors++;
          end
          if (rsp.handle_valid !== exp_rsp.handle_valid) begin
            $error("handle_valid: expected %0d, actual %0d", exp_rsp.handle_valid,
                   rsp.handle_valid);
            errors++;
          end
          if (rsp.out_index !== exp_rsp.index) begin
            $error("out_index: expected %0d, actual %0d", exp_rsp.index, rsp.out_index);
            errors++;
          end
          if (rsp.out_generation !== exp_rsp.generation) begin
            $error("out_generation: expected %0d, actual %0d", exp_rsp.generation,
                   rsp.out_generation);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_rsps.push_back(resolve_request(req.req_type, req.slot_index,
                                                req.slot_generation));
      end
    end
    outstanding <= expected_rsps.size();
  end

endmodule

[tb/generational_slot_allocator_unit_tb.sv]
`timescale 1ns / 100ps

// Top of the slot allocator testbench. It makes the request stimulus, drives
// the ready of the response channel, and gives the verdict. All prediction and
// comparison lives in the checker instantiated beside the block.
module generational_slot_allocator_unit_tb;
  import gsa_pkg::*;

  localparam int TB_MAX_SLOTS = 256;
  localparam int TB_GEN_BITS  = 16;

  // The longest hold-off of the receiver, in cycles. The sender keeps offering
  // requests during it, so the block fills up and stalls its input.
  localparam int LONG_HOLD = 300;

  // The slowest correct stretch without any transaction is the long hold-off
  // plus an idle burst of the sender and the resolving of one request in the
  // block. The watchdog allows several times that before it gives up.
  localparam int WATCHDOG_LIMIT = 2000;

  // How often the last part destroys and re-creates the same slot.
  localparam int CYCLE_ROUNDS = 16;

  typedef struct packed {
    idx_field_t idx;
    gen_field_t gen;
  } handle_t;

  typedef struct packed {
    req_kind_t  kind;
    idx_field_t idx;
    gen_field_t gen;
  } alloc_req_t;

  logic clk;
  logic rst;

  gsa_req_if req_ch ();
  gsa_rsp_if rsp_ch ();

  int fail_count;
  int outstanding;

  generational_slot_allocator_unit #(
    .MAX_SLOTS(TB_MAX_SLOTS),
    .GEN_BITS (TB_GEN_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  gsa_alloc_checker #(
    .MAX_SLOTS(TB_MAX_SLOTS),
    .GEN_BITS (TB_GEN_BITS)
  ) chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Idling on both sides is switched by this flag; the last part of the run
  // clears it. A long hold-off of the receiver is asked for through the other.
  bit idling        = 1'b1;
  bit long_hold_req = 1'b0;

  // Handles that the stimulus knows about. Live ones are learned from create
  // responses; a destroy that succeeded moves its handle to the stale list.
  handle_t    live_handles[$];
  handle_t    stale_handles[$];
  alloc_req_t sent_reqs[$];
  alloc_req_t answered;

  int n_sent     = 0;
  int n_rsp      = 0;
  int n_full     = 0;
  int n_rejected = 0;
  int quiet      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Bookkeeping of handles from the response stream. Each response belongs to
  // the oldest request that the block accepted and has not answered yet.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && sent_reqs.size() > 0) begin
      answered = sent_reqs.pop_front();
      n_rsp++;
      if (rsp_ch.status == ST_FULL) n_full++;
      if (rsp_ch.status == ST_INVALID) n_rejected++;
      if (answered.kind == REQ_CREATE && rsp_ch.handle_valid) begin
        live_handles.push_back('{rsp_ch.out_index, rsp_ch.out_generation});
      end
      if (answered.kind == REQ_DESTROY && rsp_ch.handle_valid) begin
        for (int i = 0; i < live_handles.size(); i++) begin
          if (live_handles[i].idx == answered.idx && live_handles[i].gen == answered.gen) begin
            live_handles.delete(i);
            break;
          end
        end
        stale_handles.push_back('{answered.idx, answered.gen});
        if (stale_handles.size() > 32) void'(stale_handles.pop_front());
      end
    end
  end

  // The receiver. Every pass through the loop starts at a falling edge and
  // makes one assignment to ready, so there is never a second one in a step.
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (idling && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Offers one request from the next falling edge on, possibly after an idle
  // burst, and returns at the rising edge that accepts it. Valid stays high
  // into the next call, which lowers it only if it starts with a burst.
  task automatic send_req(input req_kind_t kind, input idx_field_t idx,
                          input gen_field_t gen);
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= kind;
    req_ch.slot_index      <= idx;
    req_ch.slot_generation <= gen;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_reqs.push_back('{kind, idx, gen});
    n_sent++;
  endtask

  // The sender pauses until every outstanding response has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  function automatic req_kind_t pick_handle_kind();
    case ($urandom_range(0, 2))
      0:       return REQ_DESTROY;
      1:       return REQ_VALIDATE;
      default: return REQ_GET;
    endcase
  endfunction

  // One random request. Most requests are well formed: creates, destroys of
  // known live handles, and queries of them. The rest replays stale handles,
  // corrupts a live handle, or is noise over the whole range of every field.
  task automatic send_random(input int create_pct, input int destroy_pct);
    int      r;
    int      q;
    int      k;
    handle_t h;
    r = $urandom_range(0, 99);
    q = $urandom_range(0, 99);
    if (r < create_pct) begin
      send_req(REQ_CREATE, idx_field_t'($urandom), gen_field_t'($urandom));
    end else if (r < create_pct + destroy_pct && live_handles.size() > 0) begin
      // Taken off the list now so that no second destroy of it is issued.
      k = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[k];
      live_handles.delete(k);
      send_req(REQ_DESTROY, h.idx, h.gen);
    end else if (q < 60 && live_handles.size() > 0) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      send_req($urandom_range(0, 1) ? REQ_VALIDATE : REQ_GET, h.idx, h.gen);
    end else if (q < 75 && stale_handles.size() > 0) begin
      h = stale_handles[$urandom_range(0, stale_handles.size() - 1)];
      send_req(pick_handle_kind(), h.idx, h.gen);
    end else if (q < 87 && live_handles.size() > 0) begin
      h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      if ($urandom_range(0, 1)) begin
        h.gen = h.gen ^ (gen_field_t'(1) << $urandom_range(0, GEN_FIELD_W - 1));
      end else begin
        h.idx = h.idx + 1'b1;
      end
      send_req(pick_handle_kind(), h.idx, h.gen);
    end else begin
      send_req(req_kind_t'($urandom_range(0, 3)), idx_field_t'($urandom),
               gen_field_t'($urandom));
    end
  endtask

  // A phase of random requests with a given mix. Idling is switched on and
  // off in chunks, so that some stretches run at the full rate.
  task automatic run_phase(input int n, input int create_pct, input int destroy_pct);
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) idling = ($urandom_range(0, 3) != 0);
      send_random(create_pct, destroy_pct);
    end
  endtask

  handle_t    cycled;
  gen_field_t next_gen;

  initial begin
    rst                    = 1'b1;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_CREATE;
    req_ch.slot_index      = '0;
    req_ch.slot_generation = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. The handles below follow from a fresh pool: slot 1 comes
    // first with generation 1, and freed slots come back last in, first out.
    send_req(REQ_VALIDATE, 8'd0, 16'd0);          // the reserved slot
    send_req(REQ_GET, 8'd255, 16'hFFFF);          // never used, top of range
    send_req(REQ_DESTROY, 8'd1, 16'd1);           // not yet created
    send_req(REQ_CREATE, 8'hFF, 16'hFFFF);        // fresh slot 1, generation 1
    send_req(REQ_VALIDATE, 8'd1, 16'd1);
    send_req(REQ_VALIDATE, 8'd1, 16'd2);          // right slot, wrong generation
    send_req(REQ_GET, 8'd1, 16'd1);
    send_req(REQ_DESTROY, 8'd1, 16'd0);           // wrong generation
    send_req(REQ_DESTROY, 8'd1, 16'd1);
    send_req(REQ_VALIDATE, 8'd1, 16'd1);          // stale after destroy
    send_req(REQ_GET, 8'd1, 16'd2);               // next generation, still dead
    send_req(REQ_CREATE, 8'd0, 16'd0);            // reuses slot 1, generation 2
    send_req(REQ_CREATE, 8'd0, 16'd0);            // fresh slot 2
    send_req(REQ_DESTROY, 8'd2, 16'd1);
    send_req(REQ_DESTROY, 8'd1, 16'd2);
    send_req(REQ_CREATE, 8'd0, 16'd0);            // slot 1 pops first
    send_req(REQ_CREATE, 8'd0, 16'd0);            // then slot 2
    send_req(REQ_GET, 8'd0, 16'hFFFF);
    send_req(REQ_VALIDATE, 8'd255, 16'd0);
    send_req(REQ_DESTROY, 8'd0, 16'd0);
    send_req(REQ_GET, 8'd2, 16'd2);
    send_req(REQ_DESTROY, 8'd2, 16'hFFFF);
    drain();

    // Random part. The second phase begins with a long hold-off of the
    // receiver and fills the pool until creates report that it is exhausted;
    // the third drains it again.
    run_phase(300, 40, 25);
    long_hold_req = 1'b1;
    run_phase(300, 85, 5);
    drain();
    run_phase(350, 10, 60);
    run_phase(300, 45, 40);
    long_hold_req = 1'b1;
    run_phase(250, 60, 20);

    // Last part, with no idling: one slot is destroyed and re-created several
    // times in a row, and each new generation of it is checked to be valid.
    idling = 1'b0;
    drain();
    if (live_handles.size() == 0) begin
      send_req(REQ_CREATE, 8'd0, 16'd0);
      drain();
    end
    if (live_handles.size() > 0) begin
      cycled = live_handles.pop_front();
      send_req(REQ_DESTROY, cycled.idx, cycled.gen);
      next_gen = cycled.gen + 1'b1;
      for (int i = 0; i < CYCLE_ROUNDS; i++) begin
        send_req(REQ_CREATE, idx_field_t'($urandom), gen_field_t'($urandom));
        send_req(REQ_VALIDATE, cycled.idx, next_gen);
        send_req(REQ_DESTROY, cycled.idx, next_gen);
        next_gen = next_gen + 1'b1;
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests, got %0d responses: %0d creates on an exhausted pool,",
             n_sent, n_rsp, n_full);
    $display("%0d rejected handles, and one slot reissued %0d times at the end.",
             n_rejected, CYCLE_ROUNDS);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_req_if.sv
hw/rtl/gsa_rsp_if.sv
hw/rtl/generational_slot_allocator_unit.sv
tb/gsa_alloc_checker.sv
tb/generational_slot_allocator_unit_tb.sv
